### rtl/keypad_calculator_engine_core_assert.svh
// ----------------------------------------------------------------------------
// keypad calculator engine assertion macros
// implication checks on this block's own control logic, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CALCULATOR_ENGINE_CORE_ASSERT_SVH
`define KEYPAD_CALCULATOR_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTH
`define KCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kce assertion failed");
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kce assertion failed");
`else
`define KCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg
// types, codes, constants and saturation helpers of the calculator engine
// ----------------------------------------------------------------------------
package kce_pkg;

	localparam int FRAC_BITS = 32;
	localparam int LOG_SHIFT = 32;

	typedef logic signed [63:0] fix_t;

	localparam fix_t FIX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;
	localparam fix_t TEN_MAX = 64'sd922337203685477580;
	localparam fix_t TEN_MIN = -64'sd922337203685477580;
	localparam logic [63:0] LOG10_2 = 64'd1292913986;
	localparam logic [5:0] NORM_TOP = 6'd62;
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// key codes
	localparam logic [3:0] KEY_DIGIT  = 4'd0;
	localparam logic [3:0] KEY_POINT  = 4'd1;
	localparam logic [3:0] KEY_CLEAR  = 4'd2;
	localparam logic [3:0] KEY_ADD    = 4'd3;
	localparam logic [3:0] KEY_LOG    = 4'd9;
	localparam logic [3:0] KEY_EQUALS = 4'd10;

	// pending operation codes
	localparam logic [2:0] PEND_NONE   = 3'd0;
	localparam logic [2:0] PEND_ADD    = 3'd1;
	localparam logic [2:0] PEND_SUB    = 3'd2;
	localparam logic [2:0] PEND_MUL    = 3'd3;
	localparam logic [2:0] PEND_DIV    = 3'd4;
	localparam logic [2:0] PEND_SQRT   = 3'd5;
	localparam logic [2:0] PEND_SQUARE = 3'd6;
	localparam logic [2:0] PEND_LOG    = 3'd7;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SAT  = 2'd1;
	localparam logic [1:0] STAT_DIVZ = 2'd2;
	localparam logic [1:0] STAT_DOM  = 2'd3;

	localparam logic [7:0] MUL_STEPS  = 8'd64;
	localparam logic [7:0] DIV_STEPS  = 8'd128;
	localparam logic [7:0] SQRT_STEPS = 8'd64;

	typedef enum logic [1:0] {
		UOP_MUL,
		UOP_DIV,
		UOP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_GO,
		ST_WAIT
	} state_t;

	typedef enum logic [2:0] {
		JOB_FRAC,
		JOB_MUL,
		JOB_DIV,
		JOB_SQRT,
		JOB_LOGSQ,
		JOB_LOGSCALE
	} job_t;

	typedef struct packed {
		fix_t value;
		logic sat;
	} sres_t;

	function automatic sres_t sat_add(fix_t a, fix_t b);
		fix_t  s;
		sres_t r;
		s = a + b;
		r.sat = (a[63] == b[63]) && (s[63] != a[63]);
		r.value = r.sat ? (a[63] ? FIX_MIN : FIX_MAX) : s;
		return r;
	endfunction

	function automatic sres_t sat_sub(fix_t a, fix_t b);
		fix_t  s;
		sres_t r;
		s = a - b;
		r.sat = (a[63] != b[63]) && (s[63] != a[63]);
		r.value = r.sat ? (a[63] ? FIX_MIN : FIX_MAX) : s;
		return r;
	endfunction

	// signed result from a sign and a wide magnitude, saturating
	function automatic sres_t from_mag(logic neg, logic [127:0] v);
		sres_t r;
		if (neg) begin
			r.sat = (v[127:64] != '0) || (v[63:0] > 64'h8000_0000_0000_0000);
			r.value = r.sat ? FIX_MIN : fix_t'(64'd0 - v[63:0]);
		end else begin
			r.sat = (v[127:64] != '0) || v[63];
			r.value = r.sat ? FIX_MAX : fix_t'(v[63:0]);
		end
		return r;
	endfunction

	function automatic logic [63:0] pow10(logic [4:0] k);
		logic [63:0] p;
		unique case (k)
			5'd0:    p = 64'd1;
			5'd1:    p = 64'd10;
			5'd2:    p = 64'd100;
			5'd3:    p = 64'd1000;
			5'd4:    p = 64'd10000;
			5'd5:    p = 64'd100000;
			5'd6:    p = 64'd1000000;
			5'd7:    p = 64'd10000000;
			5'd8:    p = 64'd100000000;
			5'd9:    p = 64'd1000000000;
			5'd10:   p = 64'd10000000000;
			5'd11:   p = 64'd100000000000;
			5'd12:   p = 64'd1000000000000;
			5'd13:   p = 64'd10000000000000;
			5'd14:   p = 64'd100000000000000;
			5'd15:   p = 64'd1000000000000000;
			default: p = 64'd10000000000000000;
		endcase
		return p;
	endfunction

endpackage

### rtl/kce_if.sv
// ----------------------------------------------------------------------------
// kce channel interfaces
// key channel and result channel, valid/ready with payload
// ----------------------------------------------------------------------------
interface kce_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] opcode;
	logic [3:0] digit;

	modport source (output valid, opcode, digit, input ready);
	modport sink (input valid, opcode, digit, output ready);
endinterface

interface kce_res_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] display_value;
	logic               showing_result;
	logic [2:0]         pending_operation;
	logic [1:0]         status;

	modport source (output valid, display_value, showing_result, pending_operation, status,
		input ready);
	modport sink (input valid, display_value, showing_result, pending_operation, status,
		output ready);
endinterface

### rtl/kce_unit.sv
// ----------------------------------------------------------------------------
// kce_unit
// iterative multiply, divide and square root on one shared adder
// ----------------------------------------------------------------------------
`include "keypad_calculator_engine_core_assert.svh"

module kce_unit import kce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  unit_cmd_t    cmd,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [127:0] res
);

	logic         busy_q;
	logic         done_q;
	unit_op_t     uop_q;
	logic [7:0]   cnt_q;
	logic [127:0] acc_q;
	logic [67:0]  rem_q;
	logic [63:0]  root_q;

	logic [67:0]  lhs;
	logic [67:0]  rhs;
	logic [67:0]  rhs_x;
	logic         sub;
	logic [68:0]  sum;
	logic         ge;
	logic [67:0]  mul_hi;

	// shared adder: add for multiply, trial subtract for divide and root
	always_comb begin
		unique case (uop_q)
			UOP_DIV: begin
				lhs = {rem_q[66:0], acc_q[127]};
				rhs = {4'b0, den};
				sub = 1'b1;
			end
			UOP_SQRT: begin
				lhs = {rem_q[65:0], acc_q[127:126]};
				rhs = {2'b0, root_q, 2'b01};
				sub = 1'b1;
			end
			default: begin
				lhs = rem_q;
				rhs = {4'b0, den};
				sub = 1'b0;
			end
		endcase
		rhs_x = sub ? ~rhs : rhs;
		sum = {1'b0, lhs} + {1'b0, rhs_x} + 69'(sub);
		ge = sum[68];
		mul_hi = acc_q[0] ? sum[67:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			uop_q <= UOP_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				uop_q <= cmd.op;
				unique case (cmd.op)
					UOP_DIV:  cnt_q <= DIV_STEPS;
					UOP_SQRT: cnt_q <= SQRT_STEPS;
					default:  cnt_q <= MUL_STEPS;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= num;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			unique case (uop_q)
				UOP_DIV: begin
					rem_q <= ge ? sum[67:0] : lhs;
					acc_q <= {acc_q[126:0], ge};
				end
				UOP_SQRT: begin
					rem_q <= ge ? sum[67:0] : lhs;
					root_q <= {root_q[62:0], ge};
					acc_q <= {acc_q[125:0], 2'b00};
				end
				default: begin
					rem_q <= {1'b0, mul_hi[67:1]};
					acc_q <= {acc_q[127:64], mul_hi[0], acc_q[63:1]};
				end
			endcase
		end
	end

	always_comb begin
		unique case (uop_q)
			UOP_DIV:  res = acc_q;
			UOP_SQRT: res = {64'b0, root_q};
			default:  res = {rem_q[63:0], acc_q[63:0]};
		endcase
	end

	assign done = done_q;

	`KCE_ASSERT_IMP(a_no_restart, clk, arst_n, cmd.start, !busy_q)
	`KCE_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`KCE_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q && !cmd.start)

endmodule

### rtl/keypad_calculator_engine_core.sv
// ----------------------------------------------------------------------------
// keypad_calculator_engine_core
// calculator key engine: decimal entry, operators and equals in signed Q32.32
// ----------------------------------------------------------------------------
//  channel | dir | payload                                           | transfer
//  key     | in  | opcode[3:0], digit[3:0]                           | valid & ready
//  res     | out | display_value[63:0], showing_result,              | valid & ready
//          |     | pending_operation[2:0], status[1:0]               |
//
//  one key in, one result out; no key is taken until the last result is transferred
//  entry, clear, operator keys, add/sub/no-op and error equals: result registered in the cycle after the key transfer
//  fraction digit and divide: result from the 128-step divide in kce_unit
//  multiply, square, root: 64 steps of the shared adder
//  log10: normalize, then 32 squarings and a scaling multiply on the shared adder
//  reset clears the architectural state at once; operand registers have no reset; no clearing pass
// ----------------------------------------------------------------------------
`include "keypad_calculator_engine_core_assert.svh"

module keypad_calculator_engine_core import kce_pkg::*; #(
	parameter int MAX_DIGITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	kce_key_if.sink   key,
	kce_res_if.source res
);

	// architectural state
	state_t       state_q;
	state_t       state_d;
	job_t         job_q;
	fix_t         entry_q;
	fix_t         first_q;
	logic [2:0]   pend_q;
	logic         shown_q;
	logic [4:0]   dcnt_q;
	logic [4:0]   ppos_q;
	logic         pseen_q;
	logic [1:0]   st_q;
	logic         out_vld_q;

	// operand and log working registers
	logic [127:0] num_q;
	logic [63:0]  den_q;
	logic         neg_q;
	logic [5:0]   p_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [5:0]   iter_q;

	unit_cmd_t    u_cmd;
	logic         u_done;
	logic [127:0] u_res;

	logic         accept;

	// key decode results
	fix_t         nx_entry;
	fix_t         nx_first;
	logic [2:0]   nx_pend;
	logic         nx_shown;
	logic [4:0]   nx_dcnt;
	logic [4:0]   nx_ppos;
	logic         nx_pseen;
	logic [1:0]   nx_st;
	logic [127:0] nx_num;
	logic [63:0]  nx_den;
	logic         nx_neg;
	logic         dec_go;
	logic         dec_norm;
	job_t         dec_job;

	fix_t         e0;
	logic [4:0]   dc0;
	logic [4:0]   pp0;
	logic         ps0;
	logic [2:0]   pend0;
	logic [4:0]   frac_k;
	logic [63:0]  p10;
	logic [63:0]  frac_num;
	fix_t         e10;
	fix_t         t10;
	logic         t10_sat;
	sres_t        int_sa;
	sres_t        add_r;
	sres_t        sub_r;
	logic [63:0]  mag_a;
	logic [63:0]  mag_b;

	// unit completion
	sres_t        wres;
	logic [63:0]  msq;
	logic [63:0]  msq_adj;
	logic [FRAC_BITS-1:0] frac_nx;
	logic signed [6:0] ip;
	logic [63:0]  l2;
	logic [63:0]  l2_mag;
	logic         log_last;

	assign accept = key.valid && key.ready;

	// integer digit path: saturated entry * 10, then add the digit
	always_comb begin
		e0 = shown_q ? '0 : entry_q;
		dc0 = shown_q ? '0 : dcnt_q;
		pp0 = shown_q ? '0 : ppos_q;
		ps0 = shown_q ? 1'b0 : pseen_q;
		pend0 = shown_q ? PEND_NONE : pend_q;
		// fraction digit weight, this digit included
		frac_k = 5'(dc0 + 5'd1 - pp0);
		p10 = pow10(frac_k);
		frac_num = (64'(key.digit) << FRAC_BITS) + (p10 >> 1);
		e10 = (e0 <<< 3) + (e0 <<< 1);
		t10_sat = (e0 > TEN_MAX) || (e0 < TEN_MIN);
		if (e0 > TEN_MAX) begin
			t10 = FIX_MAX;
		end else if (e0 < TEN_MIN) begin
			t10 = FIX_MIN;
		end else begin
			t10 = e10;
		end
		int_sa = sat_add(t10, fix_t'(64'(key.digit) << FRAC_BITS));
		add_r = sat_add(first_q, entry_q);
		sub_r = sat_sub(first_q, entry_q);
		mag_a = first_q[63] ? 64'd0 - 64'(first_q) : 64'(first_q);
		mag_b = entry_q[63] ? 64'd0 - 64'(entry_q) : 64'(entry_q);
	end

	// key decode
	always_comb begin
		nx_entry = entry_q;
		nx_first = first_q;
		nx_pend = pend_q;
		nx_shown = shown_q;
		nx_dcnt = dcnt_q;
		nx_ppos = ppos_q;
		nx_pseen = pseen_q;
		nx_st = STAT_OK;
		nx_num = num_q;
		nx_den = den_q;
		nx_neg = neg_q;
		dec_go = 1'b0;
		dec_norm = 1'b0;
		dec_job = JOB_FRAC;
		if ((key.opcode == KEY_DIGIT && key.digit <= DIGIT_MAX) || key.opcode == KEY_POINT) begin
			// a digit or point after a result starts a new entry
			nx_entry = e0;
			nx_dcnt = dc0;
			nx_ppos = pp0;
			nx_pseen = ps0;
			nx_pend = pend0;
			nx_shown = 1'b0;
			if (key.opcode == KEY_POINT) begin
				if (!ps0) begin
					nx_pseen = 1'b1;
					nx_ppos = dc0;
				end
			end else if (dc0 < 5'(MAX_DIGITS)) begin
				nx_dcnt = dc0 + 5'd1;
				if (ps0) begin
					// rounded digit / 10^k through the divider
					nx_num = 128'(frac_num);
					nx_den = p10;
					dec_go = 1'b1;
					dec_job = JOB_FRAC;
				end else begin
					nx_entry = int_sa.value;
					nx_st = (t10_sat || int_sa.sat) ? STAT_SAT : STAT_OK;
				end
			end
		end else if (key.opcode == KEY_CLEAR) begin
			nx_entry = '0;
			nx_dcnt = '0;
			nx_ppos = '0;
			nx_pseen = 1'b0;
			nx_pend = PEND_NONE;
			nx_shown = 1'b0;
		end else if (key.opcode >= KEY_ADD && key.opcode <= KEY_LOG) begin
			nx_first = entry_q;
			nx_entry = '0;
			nx_dcnt = '0;
			nx_ppos = '0;
			nx_pseen = 1'b0;
			nx_pend = 3'(key.opcode - KEY_ADD + 4'd1);
			nx_shown = 1'b0;
		end else if (key.opcode == KEY_EQUALS) begin
			nx_dcnt = '0;
			nx_ppos = '0;
			nx_pseen = 1'b0;
			nx_pend = PEND_NONE;
			nx_shown = 1'b1;
			unique case (pend_q)
				PEND_ADD: begin
					nx_entry = add_r.value;
					nx_first = add_r.value;
					nx_st = add_r.sat ? STAT_SAT : STAT_OK;
				end
				PEND_SUB: begin
					nx_entry = sub_r.value;
					nx_first = sub_r.value;
					nx_st = sub_r.sat ? STAT_SAT : STAT_OK;
				end
				PEND_MUL: begin
					nx_num = 128'(mag_a);
					nx_den = mag_b;
					nx_neg = first_q[63] ^ entry_q[63];
					dec_go = 1'b1;
					dec_job = JOB_MUL;
				end
				PEND_SQUARE: begin
					nx_num = 128'(mag_a);
					nx_den = mag_a;
					nx_neg = 1'b0;
					dec_go = 1'b1;
					dec_job = JOB_MUL;
				end
				PEND_DIV: begin
					if (entry_q == '0) begin
						nx_entry = '0;
						nx_first = '0;
						nx_st = STAT_DIVZ;
					end else begin
						nx_num = 128'(mag_a) << FRAC_BITS;
						nx_den = mag_b;
						nx_neg = first_q[63] ^ entry_q[63];
						dec_go = 1'b1;
						dec_job = JOB_DIV;
					end
				end
				PEND_SQRT: begin
					if (first_q[63]) begin
						nx_entry = '0;
						nx_first = '0;
						nx_st = STAT_DOM;
					end else begin
						nx_num = 128'(64'(first_q)) << FRAC_BITS;
						dec_go = 1'b1;
						dec_job = JOB_SQRT;
					end
				end
				PEND_LOG: begin
					if (first_q[63] || first_q == '0) begin
						nx_entry = '0;
						nx_first = '0;
						nx_st = STAT_DOM;
					end else begin
						nx_den = 64'(first_q);
						dec_norm = 1'b1;
					end
				end
				default: begin
					// nothing pending: the entry is the result
					nx_first = entry_q;
				end
			endcase
		end
	end

	// unit result handling
	always_comb begin
		unique case (job_q)
			JOB_FRAC:     wres = sat_add(entry_q, fix_t'(u_res[63:0]));
			JOB_DIV:      wres = from_mag(neg_q, u_res);
			JOB_LOGSCALE: wres = from_mag(neg_q, u_res >> LOG_SHIFT);
			JOB_SQRT: begin
				wres.value = fix_t'(u_res[63:0]);
				wres.sat = 1'b0;
			end
			default:      wres = from_mag(neg_q, u_res >> FRAC_BITS);
		endcase
		// mantissa square in Q2.62, halved into Q1.62 when it reaches two
		msq = u_res[125:62];
		msq_adj = msq[63] ? (msq >> 1) : msq;
		frac_nx = {frac_q[FRAC_BITS-2:0], msq[63]};
		log_last = (iter_q == 6'(FRAC_BITS - 1));
		ip = 7'(p_q) - 7'(FRAC_BITS);
		l2 = (64'(ip) << FRAC_BITS) + 64'(frac_nx);
		l2_mag = l2[63] ? 64'd0 - l2 : l2;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && dec_go) begin
					state_d = ST_GO;
				end else if (accept && dec_norm) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (den_q[62]) begin
					state_d = ST_GO;
				end
			end
			ST_GO: state_d = ST_WAIT;
			ST_WAIT: begin
				if (u_done) begin
					state_d = (job_q == JOB_LOGSQ) ? ST_GO : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		key.ready = (state_q == ST_IDLE) && !out_vld_q;
		u_cmd.start = (state_q == ST_GO);
		unique case (job_q)
			JOB_FRAC, JOB_DIV: u_cmd.op = UOP_DIV;
			JOB_SQRT:          u_cmd.op = UOP_SQRT;
			default:           u_cmd.op = UOP_MUL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= JOB_FRAC;
			entry_q <= '0;
			first_q <= '0;
			pend_q <= PEND_NONE;
			shown_q <= 1'b0;
			dcnt_q <= '0;
			ppos_q <= '0;
			pseen_q <= 1'b0;
			st_q <= STAT_OK;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res.valid && res.ready) begin
				out_vld_q <= 1'b0;
			end
			if (accept) begin
				entry_q <= nx_entry;
				first_q <= nx_first;
				pend_q <= nx_pend;
				shown_q <= nx_shown;
				dcnt_q <= nx_dcnt;
				ppos_q <= nx_ppos;
				pseen_q <= nx_pseen;
				st_q <= nx_st;
				job_q <= dec_job;
				out_vld_q <= !(dec_go || dec_norm);
			end
			if (state_q == ST_NORM && den_q[62]) begin
				job_q <= JOB_LOGSQ;
			end
			if (state_q == ST_WAIT && u_done) begin
				if (job_q == JOB_LOGSQ) begin
					if (log_last) begin
						job_q <= JOB_LOGSCALE;
					end
				end else begin
					entry_q <= wres.value;
					if (job_q != JOB_FRAC) begin
						first_q <= wres.value;
					end
					st_q <= wres.sat ? STAT_SAT : STAT_OK;
					out_vld_q <= 1'b1;
				end
			end
		end
	end

	// operand registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			num_q <= nx_num;
			den_q <= nx_den;
			neg_q <= nx_neg;
			if (dec_norm) begin
				p_q <= NORM_TOP;
				iter_q <= '0;
				frac_q <= '0;
			end
		end
		if (state_q == ST_NORM) begin
			if (den_q[62]) begin
				num_q <= 128'(den_q);
			end else begin
				den_q <= den_q << 1;
				p_q <= p_q - 6'd1;
			end
		end
		if (state_q == ST_WAIT && u_done && job_q == JOB_LOGSQ) begin
			frac_q <= frac_nx;
			iter_q <= iter_q + 6'd1;
			if (log_last) begin
				num_q <= 128'(l2_mag);
				den_q <= LOG10_2;
				neg_q <= l2[63];
			end else begin
				num_q <= 128'(msq_adj);
				den_q <= msq_adj;
			end
		end
	end

	kce_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (u_cmd),
		.num    (num_q),
		.den    (den_q),
		.done   (u_done),
		.res    (u_res)
	);

	assign res.valid = out_vld_q;
	assign res.display_value = entry_q;
	assign res.showing_result = shown_q;
	assign res.pending_operation = pend_q;
	assign res.status = st_q;

	`KCE_ASSERT_NXT(a_accept_busy, clk, arst_n, key.valid && key.ready, state_q != ST_IDLE || out_vld_q)
	`KCE_ASSERT_IMP(a_result_no_pending, clk, arst_n, shown_q, pend_q == PEND_NONE)
	`KCE_ASSERT_IMP(a_done_in_wait, clk, arst_n, u_done, state_q == ST_WAIT)

endmodule
